/* sv/pcbm_pkg.sv */
// Shared types, constants and divider constants for the cell balance mask block.
// No dependencies; imported by every module of the block.
package pcbm_pkg;

  localparam int unsigned CHIP_COUNT     = 6;
  localparam int unsigned CELLS_PER_CHIP = 18;
  localparam int unsigned FIXED_CELLS    = 18;
  localparam int unsigned LIMIT_UNIT     = 10000;

  localparam int unsigned CHIP_W  = 3;
  localparam int unsigned CELL_W  = 5;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned MASK_W  = 18;
  localparam int unsigned TOTAL_W = 23;
  localparam int unsigned AVG_W   = 16;
  localparam int unsigned THR_W   = 16;
  localparam int unsigned LIM_W   = 8;
  localparam int unsigned LIMP_W  = 22;  // pack_limit * 10000 fits 22 bits
  localparam int unsigned UNIT_W  = 14;

  localparam logic [THR_W-1:0]   THRESH_RESET = 16'd100;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX    = {TOTAL_W{1'b1}};
  localparam logic [AVG_W-1:0]   AVG_MAX      = {AVG_W{1'b1}};

  // Divide by FIXED_CELLS * CHIP_COUNT as multiply by a rounded-up reciprocal.
  // With shift TOTAL_W + clog2(divisor) the quotient is exact for every total.
  localparam int unsigned DIVISOR   = FIXED_CELLS * CHIP_COUNT;
  localparam int unsigned DIV_LOG   = $clog2(DIVISOR);
  localparam int unsigned DIV_SHIFT = TOTAL_W + DIV_LOG;
  localparam int unsigned MULT_W    = TOTAL_W + 1;
  localparam logic [63:0] DIV_MULT_64 =
    ((64'd1 << DIV_SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [MULT_W-1:0] DIV_MULT = DIV_MULT_64[MULT_W-1:0];
  localparam int unsigned PROD_W = TOTAL_W + MULT_W;

  typedef enum logic {
    REQ_AVERAGE = 1'b0,
    REQ_BALANCE = 1'b1
  } req_e;

  typedef enum logic {
    KIND_AVERAGE = 1'b0,
    KIND_MASK    = 1'b1
  } kind_e;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_LIMIT     = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    req_e              req_type;
    logic [CHIP_W-1:0] chip_index;
    logic [CELL_W-1:0] cell_index;
    logic [CODE_W-1:0] cell_code;
    logic              round_last;
  } item_t;

  typedef struct packed {
    logic [TOTAL_W-1:0] pack_total;
    logic [AVG_W-1:0]   average_code;
    logic               over_limit;
  } avg_res_t;

  typedef struct packed {
    logic [MASK_W-1:0] discharge_mask;
    logic              no_discharge;
  } mask_res_t;

endpackage

/* sv/pcbm_avg.sv */
// Averaging round: saturating pack sum, reciprocal divide and limit compare.
// Depends on pcbm_pkg.
module pcbm_avg import pcbm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,        // averaging word processed this cycle
  input  item_t               item_i,
  input  logic [LIMP_W-1:0]   limit_i,
  output avg_res_t            res_o,
  output logic [AVG_W-1:0]    average_o    // stored average for balancing
);

  logic [TOTAL_W-1:0] total_q, total_d;
  logic [AVG_W-1:0]   avg_q, avg_d;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_new;
  logic [PROD_W-1:0]  prod;
  logic [TOTAL_W-1:0] quot;
  logic [AVG_W-1:0]   quot_sat;
  logic               chip_ok;

  always_comb begin
    chip_ok   = {29'd0, item_i.chip_index} < CHIP_COUNT;
    sum       = {1'b0, total_q} + (TOTAL_W + 1)'(item_i.cell_code);
    if (!chip_ok) begin
      total_new = total_q;
    end else if (sum[TOTAL_W]) begin
      total_new = TOTAL_MAX;
    end else begin
      total_new = sum[TOTAL_W-1:0];
    end
    prod     = PROD_W'(total_new) * PROD_W'(DIV_MULT);
    quot     = TOTAL_W'(prod >> DIV_SHIFT);
    quot_sat = (quot > TOTAL_W'(AVG_MAX)) ? AVG_MAX : quot[AVG_W-1:0];

    res_o.pack_total   = total_new;
    res_o.average_code = quot_sat;
    res_o.over_limit   = total_new > TOTAL_W'(limit_i);

    total_d = total_q;
    avg_d   = avg_q;
    if (en_i) begin
      if (item_i.round_last) begin
        total_d = '0;
        avg_d   = quot_sat;
      end else begin
        total_d = total_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      avg_q   <= '0;
    end else begin
      total_q <= total_d;
      avg_q   <= avg_d;
    end
  end

  assign average_o = avg_q;

endmodule

/* sv/pcbm_mask.sv */
// Balancing round: threshold compare and per-chip discharge mask gathering.
// Depends on pcbm_pkg.
module pcbm_mask import pcbm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,       // balancing word processed this cycle
  input  logic               emit_i,     // this word closes the mask
  input  item_t              item_i,
  input  logic [AVG_W-1:0]   average_i,
  input  logic [THR_W-1:0]   thresh_i,
  output mask_res_t          res_o
);

  logic [MASK_W-1:0] mask_q, mask_d, mask_new;
  logic              any_q, any_d;
  logic              hit;
  logic [AVG_W:0]    bound;

  always_comb begin
    bound = {1'b0, average_i} + {1'b0, thresh_i};
    hit   = ({29'd0, item_i.chip_index} < CHIP_COUNT)
         && ({27'd0, item_i.cell_index} < CELLS_PER_CHIP)
         && ({1'b0, item_i.cell_code} > bound);
    mask_new = mask_q;
    for (int n = 0; n < MASK_W; n++) begin
      if (hit && item_i.cell_index == CELL_W'(n)) begin
        mask_new[n] = 1'b1;
      end
    end

    res_o.discharge_mask = mask_new;
    res_o.no_discharge   = item_i.round_last && !(any_q || hit);

    mask_d = mask_q;
    any_d  = any_q;
    if (en_i) begin
      mask_d = emit_i ? '0 : mask_new;
      any_d  = item_i.round_last ? 1'b0 : (any_q || hit);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      any_q  <= 1'b0;
    end else begin
      mask_q <= mask_d;
      any_q  <= any_d;
    end
  end

endmodule

/* sv/passive_cell_balance_mask.sv */
// Top level of the passive cell balance mask block: stream ports, config, staging.
// Depends on pcbm_pkg, pcbm_avg and pcbm_mask.
//
// Usage:
//  - s_axis carries one cell sample per word: tuser = req_type (0 averaging,
//    1 balancing), tlast = last sample of the round, tdata = chip, cell, code.
//  - m_axis carries one result word: tuser = result kind (0 average, 1 mask).
//    An average word comes on the last averaging sample; a mask word comes
//    on cell CELLS_PER_CHIP-1 or on the last balancing sample.
//  - cfg_we_i writes discharge_threshold (index 0) or pack_limit (index 1);
//    write only while the block is idle.
//  - A result word passes the input register, then the result register.
//  - Throughput: one sample per cycle unless a result waits; the round
//    state (sum, average, mask) is updated in the same cycle as the
//    result register, so the next sample sees it at once. The path is
//    the sum, saturate and reciprocal multiply.
//  - Reset clears sum, average, mask and flags; threshold returns to 100 and
//    pack_limit to 0. The input and result registers are empty after reset.
//  - When m_axis stalls, the result holds; one more sample that makes a
//    result is held in the input register, then s_axis_tready drops.
//    Samples that give no result keep flowing while the result waits.
module passive_cell_balance_mask import pcbm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  // sample stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // chip_index[2:0], cell_index[7:3], cell_code[23:8]
  input  logic        s_axis_tuser,   // req_type
  input  logic        s_axis_tlast,   // round_last
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // mask_chip[2:0], discharge_mask[20:3],
                                      // pack_total[43:21], average_code[59:44],
                                      // over_limit[60], no_discharge[61], zero[63:62]
  output logic        m_axis_tuser    // result_kind
);

  // config registers; pack_limit is kept as its product with the limit unit
  logic [THR_W-1:0]  thresh_q;
  logic [LIMP_W-1:0] limit_q;
  logic [LIMP_W-1:0] limit_prod;

  assign limit_prod = LIMP_W'(cfg_data_i[LIM_W-1:0]) * LIMP_W'(UNIT_W'(LIMIT_UNIT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= THRESH_RESET;
      limit_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_THRESHOLD: thresh_q <= cfg_data_i[THR_W-1:0];
        CFG_LIMIT:     limit_q  <= limit_prod;
        default:       thresh_q <= thresh_q;
      endcase
    end
  end

  // input register
  logic  in_valid_q;
  item_t in_q;
  logic  emit, advance;

  // output register
  logic        out_valid_q;
  logic [63:0] out_data_q, out_data_d;
  kind_e       out_kind_q, out_kind_d;

  always_comb begin
    case (in_q.req_type)
      REQ_AVERAGE: emit = in_q.round_last;
      REQ_BALANCE: emit = in_q.round_last
                       || (in_q.cell_index == CELL_W'(CELLS_PER_CHIP - 1));
      default:     emit = 1'b0;
    endcase
  end

  // a sample moves on unless it makes a result that cannot be placed
  assign advance       = in_valid_q && (!emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.req_type   <= req_e'(s_axis_tuser);
      in_q.chip_index <= s_axis_tdata[2:0];
      in_q.cell_index <= s_axis_tdata[7:3];
      in_q.cell_code  <= s_axis_tdata[23:8];
      in_q.round_last <= s_axis_tlast;
    end
  end

  // round units
  avg_res_t         avg_res;
  mask_res_t        mask_res;
  logic [AVG_W-1:0] average;

  pcbm_avg u_avg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance && in_q.req_type == REQ_AVERAGE),
    .item_i    (in_q),
    .limit_i   (limit_q),
    .res_o     (avg_res),
    .average_o (average)
  );

  pcbm_mask u_mask (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (advance && in_q.req_type == REQ_BALANCE),
    .emit_i    (emit),
    .item_i    (in_q),
    .average_i (average),
    .thresh_i  (thresh_q),
    .res_o     (mask_res)
  );

  // result word assembly
  always_comb begin
    out_data_d = '0;
    case (in_q.req_type)
      REQ_AVERAGE: begin
        out_kind_d         = KIND_AVERAGE;
        out_data_d[43:21]  = avg_res.pack_total;
        out_data_d[59:44]  = avg_res.average_code;
        out_data_d[60]     = avg_res.over_limit;
      end
      REQ_BALANCE: begin
        out_kind_d         = KIND_MASK;
        out_data_d[2:0]    = in_q.chip_index;
        out_data_d[20:3]   = mask_res.discharge_mask;
        out_data_d[61]     = mask_res.no_discharge;
      end
      default: begin
        out_kind_d         = KIND_AVERAGE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q <= out_data_d;
      out_kind_q <= out_kind_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_kind_q;

  // checks
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> s_axis_tready)
    else $error("input register empty but not ready");

  a_mask_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_MASK) |->
      (m_axis_tdata[60:21] == '0))
    else $error("mask word carries average fields");

  a_avg_fields_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_AVERAGE) |->
      (m_axis_tdata[20:0] == '0 && m_axis_tdata[61] == 1'b0))
    else $error("average word carries mask fields");

  a_over_needs_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_AVERAGE && m_axis_tdata[60]) |->
      (m_axis_tdata[43:21] != '0))
    else $error("over limit with zero pack total");

  a_clear_empty_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == KIND_MASK && m_axis_tdata[61]) |->
      (m_axis_tdata[20:3] == '0))
    else $error("no-discharge flag with mask bits set");

endmodule
